[src/met_pkg.sv]
// Shared types and constants for the Mandelbrot escape-time unit.
`default_nettype none
package met_pkg;

    // Fixed-point format of z and c (signed Q4.28)
    localparam int FRAC_BITS   = 28;
    localparam int COUNT_WIDTH = 16;
    localparam int MAG_WIDTH   = 35;

    // Escape bound 4.0 in the scale of the floored |z|^2
    localparam logic [63:0] MAG_BOUND = 64'd4 << FRAC_BITS;

    typedef logic [COUNT_WIDTH-1:0] t_count;

    // One input word: the point c
    typedef struct packed {
        logic signed [31:0] c_real;
        logic signed [31:0] c_imag;
    } t_in_word;

    // One output word: count, last z and its squared magnitude
    typedef struct packed {
        t_count                 iteration_count;
        logic signed [31:0]     final_real;
        logic signed [31:0]     final_imag;
        logic [MAG_WIDTH-1:0]   magnitude_sq;
    } t_out_word;

    // Front-to-back queue handshake
    typedef struct packed {
        logic     valid;
        t_in_word word;
    } t_q_head;

endpackage
`default_nettype wire

[src/mandelbrot_escape_time_unit.sv]
// Each point waits in the input queue, then the iteration engine works on it alone,
// alternating a multiply state and a check/update state per iteration, and the
// result word is registered; the input queue absorbs bursts while the engine is busy.
// Reset (synchronous, active low): queue empty, engine idle, no result pending,
// iteration limit back to 256.
`default_nettype none
module mandelbrot_escape_time_unit
    import met_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_word  i_in_word,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_word      o_out_word,
    input  wire logic      i_cfg_valid,
    output logic           o_cfg_ready,
    input  wire logic [15:0] i_cfg_data
);

    localparam t_count LIMIT_RESET = t_count'(256);

    t_count  r_max_iter;
    t_q_head w_head;
    logic    w_pop;

    // Iteration limit register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter <= LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_iter <= t_count'(i_cfg_data);
        end
    end

    met_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_head     (w_head),
        .i_pop      (w_pop)
    );

    met_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .i_limit     (r_max_iter),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule
`default_nettype wire

[src/met_queue.sv]
// Front end: input acceptance and the point queue feeding the iteration engine.
`default_nettype none
module met_queue
    import met_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_word i_in_word,
    output t_q_head       o_head,
    input  wire logic     i_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_in_word        r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            w_push;
    logic            w_pop;

    assign o_in_stall  = (r_count == FULL_CNT);
    assign w_push      = i_in_valid && !o_in_stall;
    assign w_pop       = i_pop && (r_count != '0);
    assign o_head.valid = (r_count != '0);
    assign o_head.word  = r_mem[r_rd_ptr];

    // Storage: payload only, no reset
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_in_word;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

[src/met_core.sv]
// Back end: iterates z = z*z + c for one point and registers the result word.
`default_nettype none
module met_core
    import met_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_q_head i_head,
    output logic         o_pop,
    input  wire t_count  i_limit,
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    output t_out_word    o_out_word
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_CHK  = 2'd2;

    localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

    logic [1:0]          r_state, n_state;
    logic signed [31:0]  r_cr, r_ci;
    logic signed [31:0]  r_zr, r_zi;
    t_count              r_cnt, r_limit;
    logic signed [63:0]  r_p_rr, r_p_ii, r_p_ri;
    logic                r_out_valid;
    t_out_word           r_out_word;

    logic signed [63:0]  w_m_rr, w_m_ii, w_m_ri;
    logic signed [63:0]  w_diff, w_re_sum, w_im_sum;
    logic signed [31:0]  w_new_re, w_new_im;
    logic [63:0]         w_sq_sum, w_mag;
    logic [MAG_WIDTH-1:0] w_mag_sat;
    logic                w_done, w_out_free, w_load;

    // Products of the current z (squares double as |z|^2 of the last step)
    assign w_m_rr = r_zr * r_zr;
    assign w_m_ii = r_zi * r_zi;
    assign w_m_ri = r_zr * r_zi;

    // New z from registered products: floor shift, add c, saturate
    assign w_diff   = r_p_rr - r_p_ii;
    assign w_re_sum = (w_diff >>> FRAC_BITS) + 64'(r_cr);
    assign w_im_sum = (r_p_ri >>> (FRAC_BITS - 1)) + 64'(r_ci);

    always_comb begin
        if (w_re_sum > SAT_MAX) begin
            w_new_re = SAT_MAX[31:0];
        end else if (w_re_sum < SAT_MIN) begin
            w_new_re = SAT_MIN[31:0];
        end else begin
            w_new_re = w_re_sum[31:0];
        end
        if (w_im_sum > SAT_MAX) begin
            w_new_im = SAT_MAX[31:0];
        end else if (w_im_sum < SAT_MIN) begin
            w_new_im = SAT_MIN[31:0];
        end else begin
            w_new_im = w_im_sum[31:0];
        end
    end

    // Squared magnitude of the current z, floored and saturated
    assign w_sq_sum  = $unsigned(r_p_rr) + $unsigned(r_p_ii);
    assign w_mag     = w_sq_sum >> FRAC_BITS;
    assign w_mag_sat = (w_mag[63:MAG_WIDTH] != '0) ? '1 : w_mag[MAG_WIDTH-1:0];

    assign w_done     = (r_cnt >= r_limit) || (w_mag >= MAG_BOUND);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_load     = (r_state == S_CHK) && w_done && w_out_free;
    assign o_pop      = (r_state == S_IDLE) && i_head.valid;

    // Sequencer: each iteration is a multiply state, then a check/update state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_head.valid) n_state = S_MUL;
            end
            S_MUL: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                if (!w_done) begin
                    n_state = S_MUL;
                end else if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    r_cr    <= i_head.word.c_real;
                    r_ci    <= i_head.word.c_imag;
                    r_zr    <= '0;
                    r_zi    <= '0;
                    r_cnt   <= '0;
                    r_limit <= i_limit;
                end
            end
            S_MUL: begin
                r_p_rr <= w_m_rr;
                r_p_ii <= w_m_ii;
                r_p_ri <= w_m_ri;
            end
            S_CHK: begin
                if (!w_done) begin
                    r_zr  <= w_new_re;
                    r_zi  <= w_new_im;
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
        if (w_load) begin
            r_out_word.iteration_count <= r_cnt;
            r_out_word.final_real      <= r_zr;
            r_out_word.final_imag      <= r_zi;
            r_out_word.magnitude_sq    <= w_mag_sat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
`default_nettype wire
